>>> sv/sgu_pkg.sv
`default_nettype none
package sgu_pkg;

	localparam int MaxWidth   = 2048;
	localparam int MaxHeight  = 4096;
	localparam int MinDim     = 3;
	localparam int AddrW      = $clog2(MaxWidth);
	localparam int PixW       = 8;
	localparam int GradW      = 11;
	localparam int WidthRegW  = 12;
	localparam int HeightRegW = 13;
	localparam int ColW       = 11;
	localparam int RowW       = 12;
	localparam int CfgIdxW    = 4;
	localparam int CfgDataW   = 13;

	localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = CfgIdxW'(1);

	localparam logic [WidthRegW-1:0]  WIDTH_RESET  = WidthRegW'(640);
	localparam logic [HeightRegW-1:0] HEIGHT_RESET = HeightRegW'(480);

	typedef logic [PixW-1:0]  pix_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic signed [GradW-1:0] grad_t;

	function automatic logic [WidthRegW-1:0] clamp_width(input logic [WidthRegW-1:0] v);
		if (v < WidthRegW'(MinDim)) return WidthRegW'(MinDim);
		if (v > WidthRegW'(MaxWidth)) return WidthRegW'(MaxWidth);
		return v;
	endfunction

	function automatic logic [HeightRegW-1:0] clamp_height(input logic [HeightRegW-1:0] v);
		if (v < HeightRegW'(MinDim)) return HeightRegW'(MinDim);
		if (v > HeightRegW'(MaxHeight)) return HeightRegW'(MaxHeight);
		return v;
	endfunction

endpackage
`default_nettype wire

>>> sv/sobel_gradient_3x3_unit.sv
// 3x3 Sobel gradient unit for a raster stream of 8-bit grayscale pixels.
// Input stream (s_*): one pixel per item in tdata, frame start flag in tuser.
// Output stream (m_*): grad_x and grad_y in tdata, tlast on the final
// interior result of a frame. Border centers produce no output item.
// Config channel (cfg_*): index 0 = image width, index 1 = image height;
// write only while the stream is idle. cfg_ready is always high.
// A result shows on m_tvalid from the output register, loaded when the item
// completing its window leaves stage 1, which waits while an untaken result
// is held. Throughput: one pixel per cycle while the output is not stalled,
// set by the single read and single write port of each line store (read at
// accept, write back as the item leaves stage 1, same-address reuse forwarded).
// Reset clears position counters, the window, and restores 640x480; line
// store contents are left as they are. When the receiver stalls, the output
// register holds and the input keeps flowing until one more result is
// waiting behind it, after which s_tready drops.
`default_nettype none
module sobel_gradient_3x3_unit
	import sgu_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,  // [7:0] pixel
	input  wire logic                s_tuser,  // [0] frame_start
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [23:0]              m_tdata,  // [10:0] grad_x, [21:11] grad_y, [23:22] zero
	output logic                     m_tlast,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	logic [WidthRegW-1:0]  width_q;
	logic [HeightRegW-1:0] height_q;
	logic [WidthRegW-1:0]  w_eff;
	logic [HeightRegW-1:0] h_eff;

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_cur;
	logic [RowW-1:0] row_cur;
	logic            row_end;
	logic            frame_end;

	pix_t mem_upper [MaxWidth];
	pix_t mem_middle [MaxWidth];
	pix_t rd_upper_q;
	pix_t rd_middle_q;

	logic  valid_s1;
	addr_t addr_s1;
	pix_t  pix_s1;
	logic  prod_s1;
	logic  last_s1;
	logic  fwd_s1;
	pix_t  fwd_top_s1;
	pix_t  fwd_mid_s1;

	pix_t win_q [6];

	logic  accept;
	logic  adv;
	addr_t addr_in;
	pix_t  top_e;
	pix_t  mid_e;
	grad_t gx;
	grad_t gy;

	logic  out_valid_q;
	grad_t gx_q;
	grad_t gy_q;
	logic  last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WidthRegW-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HeightRegW-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_width(width_q);
	assign h_eff = clamp_height(height_q);

	assign adv      = valid_s1 && (!prod_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	assign col_cur   = s_tuser ? '0 : col_q;
	assign row_cur   = s_tuser ? '0 : row_q;
	assign addr_in   = col_cur[AddrW-1:0];
	assign row_end   = ({1'b0, col_cur} + WidthRegW'(1)) >= w_eff;
	assign frame_end = ({1'b0, row_cur} + HeightRegW'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_cur + RowW'(1);
			end else begin
				col_q <= col_cur + ColW'(1);
				row_q <= row_cur;
			end
		end
	end

	// line stores: read at accept, write back as the item leaves stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_upper_q  <= mem_upper[addr_in];
			rd_middle_q <= mem_middle[addr_in];
		end
		if (adv) begin
			mem_upper[addr_s1]  <= mid_e;
			mem_middle[addr_s1] <= pix_s1;
		end
	end

	assign top_e = fwd_s1 ? fwd_top_s1 : rd_upper_q;
	assign mid_e = fwd_s1 ? fwd_mid_s1 : rd_middle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prod_s1  <= 1'b0;
			last_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			prod_s1  <= (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
			last_s1  <= row_end && frame_end;
			fwd_s1   <= valid_s1 && adv && (addr_s1 == addr_in);
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= addr_in;
			pix_s1     <= s_tdata;
			fwd_top_s1 <= mid_e;
			fwd_mid_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_e;
			win_q[4] <= mid_e;
			win_q[5] <= pix_s1;
		end
	end

	assign gx = grad_t'(({3'b0, top_e} + {2'b0, mid_e, 1'b0} + {3'b0, pix_s1})
		- ({3'b0, win_q[0]} + {2'b0, win_q[1], 1'b0} + {3'b0, win_q[2]}));
	assign gy = grad_t'(({3'b0, win_q[2]} + {2'b0, win_q[5], 1'b0} + {3'b0, pix_s1})
		- ({3'b0, win_q[0]} + {2'b0, win_q[3], 1'b0} + {3'b0, top_e}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && prod_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && prod_s1) begin
			gx_q   <= gx;
			gy_q   <= gy;
			last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, gy_q, gx_q};
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
	import sgu_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PIXELS = 1150;
	localparam int QUIET_CYCLES = 8;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = CfgIdxW'(15);
	localparam pix_t PIX_LO = 8'd0;
	localparam pix_t PIX_HI = 8'd255;

	typedef struct packed {
		grad_t gx;
		grad_t gy;
		logic  last;
	} grad_res_t;

	typedef struct {
		pix_t px;
		logic fs;
		bit   known;
		int   gx;
		int   gy;
		logic last;
	} probe_row_t;

	// 3 wide, 10 high: right-column, top-row, bottom-row and left-column extremes
	probe_row_t probe_rows[30] = '{
		'{PIX_LO, 1'b1, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b1, 1020, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b1, 0, -1020, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b1, 0, 1020, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_HI, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b0, 0, 0, 1'b0},
		'{PIX_LO, 1'b0, 1'b1, -1020, 0, 1'b1}
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;  // [7:0] pixel
	logic                s_tuser;  // [0] frame_start
	logic                m_tvalid;
	logic                m_tready;
	logic [23:0]         m_tdata;  // [10:0] grad_x, [21:11] grad_y, [23:22] zero
	logic                m_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// predictor state
	logic [WidthRegW-1:0]  width_reg;
	logic [HeightRegW-1:0] height_reg;
	pix_t                  upper_line[MaxWidth];
	pix_t                  middle_line[MaxWidth];
	bit [1:0]              fill_cnt[MaxWidth];
	pix_t                  win[6];
	int                    col_pos;
	int                    row_pos;
	grad_res_t             grad_due[$];

	int        errors = 0;
	int        results_seen = 0;
	int        frame_ends = 0;
	int        pixels_sent = 0;
	int        settings_done = 0;
	int        cycle_count = 0;
	int        tx_calm = 0;
	int        rx_calm = 0;
	int        rx_stall = 0;
	int        hold_trigger = 32'h7fff_ffff;
	bit        hold_active = 1'b0;
	grad_res_t want_res;
	grad_t     seen_gx;
	grad_t     seen_gy;

	sobel_gradient_3x3_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 45) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_t rand_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return PIX_LO;
		if (r == 1) return PIX_HI;
		return pix_t'($urandom_range(0, 255));
	endfunction

	// columns at the left whose both line stores hold written pixels
	function automatic int ready_cols();
		int c;
		for (c = 0; c < MaxWidth; c++)
			if (fill_cnt[c] != 2'd2) break;
		return c;
	endfunction

	function automatic bit sobel_step(input pix_t px, input logic fs, output grad_res_t res);
		int w, h, top, mid, bot, sx, sy, c;
		bit made;
		w = int'(width_reg);
		if (w < MinDim) w = MinDim;
		if (w > MaxWidth) w = MaxWidth;
		h = int'(height_reg);
		if (h < MinDim) h = MinDim;
		if (h > MaxHeight) h = MaxHeight;
		made = 1'b0;
		res = '0;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos % MaxWidth;
		top = int'(upper_line[c]);
		mid = int'(middle_line[c]);
		bot = int'(px);
		if (row_pos >= 2 && col_pos >= 2) begin
			sx = (top + 2 * mid + bot) - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
			sy = (int'(win[2]) + 2 * int'(win[5]) + bot) - (int'(win[0]) + 2 * int'(win[3]) + top);
			res.gx = grad_t'(sx);
			res.gy = grad_t'(sy);
			res.last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
			made = 1'b1;
		end
		upper_line[c] = pix_t'(mid);
		middle_line[c] = px;
		if (fill_cnt[c] != 2'd2) fill_cnt[c] = fill_cnt[c] + 2'd1;
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = pix_t'(top);
		win[4] = pix_t'(mid);
		win[5] = px;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h)
				row_pos = 0;
			else
				row_pos++;
		end else begin
			col_pos++;
		end
		return made;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		if (errors <= 40)
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IMAGE_WIDTH: width_reg = val[WidthRegW-1:0];
			CFG_IMAGE_HEIGHT: height_reg = val;
			default: ;
		endcase
		settings_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input pix_t px, input logic fs, input bit known,
			input grad_res_t typed);
		int gap;
		grad_res_t res;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tuser <= fs;
		do @(posedge clk); while (!s_tready);
		if (sobel_step(px, fs, res) || known) begin
			if (known) res = typed;
			grad_due.push_back(res);
		end
		pixels_sent++;
		@(negedge clk);
	endtask

	// block may still hold a border pixel in flight when the queue drains
	task automatic wait_idle();
		while (grad_due.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [CfgDataW-1:0] wd, input logic [CfgDataW-1:0] hd,
			input int n, input bit fresh);
		int i;
		logic fs;
		wait_idle();
		cfg_write(CFG_IMAGE_WIDTH, wd);
		cfg_write(CFG_IMAGE_HEIGHT, hd);
		for (i = 0; i < n; i++) begin
			fs = (i == 0 && fresh) || ($urandom_range(0, 199) == 0);
			send_pixel(rand_pixel(), fs, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			rx_stall = pick_gap(rx_calm);
			seen_gx = grad_t'(m_tdata[10:0]);
			seen_gy = grad_t'(m_tdata[21:11]);
			if (m_tlast) frame_ends++;
			if (grad_due.size() == 0) begin
				report_mismatch("unexpected item", 0, 1);
			end else begin
				want_res = grad_due.pop_front();
				if (seen_gx != want_res.gx) report_mismatch("grad_x", want_res.gx, seen_gx);
				if (seen_gy != want_res.gy) report_mismatch("grad_y", want_res.gy, seen_gy);
				if (m_tlast != want_res.last) report_mismatch("tlast", want_res.last, m_tlast);
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !(hold_active || rx_stall > 0);
		if (rx_stall > 0) rx_stall--;
	end

	// long output stall while the sender keeps pushing pixels
	initial begin
		while (results_seen < hold_trigger) @(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int i, r, lim, rand_base;
		bit fresh;
		logic [CfgDataW-1:0] wd, hd;
		grad_res_t typed;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		col_pos = 0;
		row_pos = 0;
		for (i = 0; i < MaxWidth; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
			fill_cnt[i] = 2'd0;
		end
		for (i = 0; i < 6; i++) win[i] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(3));
		cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(10));
		for (i = 0; i < 30; i++) begin
			typed.gx = grad_t'(probe_rows[i].gx);
			typed.gy = grad_t'(probe_rows[i].gy);
			typed.last = probe_rows[i].last;
			send_pixel(probe_rows[i].px, probe_rows[i].fs, probe_rows[i].known, typed);
		end
		s_tvalid <= 1'b0;

		// part of a widest row (width field masked and clamped), a width that only
		// the mask brings down to 3, then tallest frame, then smallest
		run_phase(CfgDataW'(13'h1FFF), CfgDataW'(3), 120, 1'b1);
		run_phase(CfgDataW'(13'h1003), CfgDataW'(3), 30, 1'b1);
		run_phase(CfgDataW'(5), CfgDataW'(13'h1FFF), 120, 1'b1);
		run_phase(CfgDataW'(0), CfgDataW'(0), 60, 1'b1);
		// width shrinks and height drops to make the current row the last, then width grows
		run_phase(CfgDataW'(12), CfgDataW'(6), 40, 1'b1);
		run_phase(CfgDataW'(5), CfgDataW'(4), 40, 1'b0);
		run_phase(CfgDataW'(9), CfgDataW'(7), 50, 1'b0);

		rand_base = pixels_sent;
		hold_trigger = results_seen + 40;
		run_phase(CfgDataW'(8), CfgDataW'(6), 400, 1'b1);

		while (pixels_sent - rand_base < RAND_PIXELS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				cfg_write(CFG_SPARE, CfgDataW'($urandom_range(0, 8191)));
			end
			fresh = $urandom_range(0, 4) != 0;
			r = $urandom_range(0, 99);
			if (r < 70) wd = CfgDataW'($urandom_range(3, 12));
			else if (r < 88) wd = CfgDataW'($urandom_range(13, 64));
			else if (r < 95) wd = CfgDataW'($urandom_range(65, 300));
			else wd = CfgDataW'($urandom_range(0, 8191));
			r = $urandom_range(0, 99);
			if (r < 60) hd = CfgDataW'($urandom_range(3, 8));
			else if (r < 85) hd = CfgDataW'($urandom_range(9, 40));
			else hd = CfgDataW'($urandom_range(0, 8191));
			if (!fresh) begin
				lim = ready_cols();
				if (lim < MinDim)
					fresh = 1'b1;
				else
					wd = CfgDataW'($urandom_range(MinDim, (lim > 64) ? 64 : lim));
			end
			run_phase(wd, hd, $urandom_range(20, 200), fresh);
		end

		while (grad_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Streamed %0d pixels, %0d register writes; %0d gradient items checked.",
			pixels_sent, settings_done, results_seen);
		$display("%0d frames closed; clamped sizes, size changes, restarts, %0d-cycle hold.",
			frame_ends, HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
sv/sgu_pkg.sv
sv/sobel_gradient_3x3_unit.sv
test/tb_top.sv
